FILE: src/best_fit_decreasing_quota_check_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the best-fit-decreasing quota check.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_DECREASING_QUOTA_CHECK_ASSERT_SVH
`define BEST_FIT_DECREASING_QUOTA_CHECK_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define BFDQC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bfdqc: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BFDQC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bfdqc: assertion failed");

`else

`define BFDQC_ASSERT_SAME(lbl, ante, cons)
`define BFDQC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: src/bfdqc_pkg.sv
// ----------------------------------------------------------------------------
// bfdqc_pkg
// Beat types and function codes shared by the quota check files.
// ----------------------------------------------------------------------------
package bfdqc_pkg;

    localparam int AMOUNT_WIDTH = 48;

    typedef logic [1:0] t_func;

    localparam t_func FUNC_LOAD_LOC = 2'd0;
    localparam t_func FUNC_LOAD_REQ = 2'd1;
    localparam t_func FUNC_EVAL     = 2'd2;

    typedef struct packed {
        t_func                          func;
        logic signed [AMOUNT_WIDTH-1:0] amount;
    } t_in_beat;

    typedef struct packed {
        logic satisfiable;
        logic overflow;
    } t_out_beat;

endpackage

FILE: src/bfdqc_ram.sv
// ----------------------------------------------------------------------------
// bfdqc_ram
// Generic RAM with one write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bfdqc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/best_fit_decreasing_quota_check.sv
// ----------------------------------------------------------------------------
// best_fit_decreasing_quota_check
// Checks whether loaded space requests fit on loaded storage locations when
// placed largest first, each on the tightest location that still holds it.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid, o_in_stall, i_in_data) carries one beat per
// item. A load beat (location free space or request size) is written to its
// RAM at the current fill count; loads follow each other back to back. A
// load into a full store is dropped and noted.
// An evaluate beat starts the placement. For each request the request RAM is
// swept for the largest entry, that entry is removed by moving the last one
// into its slot, the location RAM is swept for the best fit and the chosen
// location is written back with its remaining space. If no location holds
// the request, the evaluation ends unsatisfied. Each store has a single RAM
// read port. o_in_stall is high throughout.
// The result beat (o_out_valid, i_out_stall, o_out_data) sits in an output
// register; further loads are accepted while it waits. A second evaluation
// holds in its final state until the first result has been taken.
// Both stores are emptied when the result is issued. Reset clears the fill
// counts, the overflow flag and the output valid flag; RAM contents are left.
// ----------------------------------------------------------------------------
`include "best_fit_decreasing_quota_check_assert.svh"

module best_fit_decreasing_quota_check #(
    parameter int MAX_LOCATIONS = 16,
    parameter int MAX_REQUESTS  = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bfdqc_pkg::t_in_beat  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bfdqc_pkg::t_out_beat o_out_data
);

    localparam int W  = bfdqc_pkg::AMOUNT_WIDTH;
    localparam int LA = (MAX_LOCATIONS > 1) ? $clog2(MAX_LOCATIONS) : 1;
    localparam int RA = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int LC = $clog2(MAX_LOCATIONS + 1);
    localparam int RC = $clog2(MAX_REQUESTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RSCAN,
        S_RFIX,
        S_LSCAN,
        S_LFIX,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [LC-1:0]         r_lcnt;
    logic [RC-1:0]         r_rcnt;
    logic                  r_ovf;
    logic [LC-1:0]         r_laddr;
    logic [RC-1:0]         r_raddr;
    logic                  r_rd_v;
    logic [RA-1:0]         r_rd_ridx;
    logic [LA-1:0]         r_rd_lidx;
    logic signed [W-1:0]   r_max;
    logic [RA-1:0]         r_maxidx;
    logic signed [W-1:0]   r_last;
    logic signed [W-1:0]   r_req;
    logic                  r_found;
    logic signed [W-1:0]   r_best;
    logic [LA-1:0]         r_bestidx;
    logic                  r_ok;
    logic                  r_out_v;
    bfdqc_pkg::t_out_beat  r_out;

    logic                  w_loc_we;
    logic [LA-1:0]         w_loc_waddr;
    logic [W-1:0]          w_loc_wdata;
    logic [W-1:0]          w_loc_rdata;
    logic                  w_req_we;
    logic [RA-1:0]         w_req_waddr;
    logic [W-1:0]          w_req_wdata;
    logic [W-1:0]          w_req_rdata;
    logic signed [W-1:0]   w_loc_rs;
    logic signed [W-1:0]   w_req_rs;
    logic [W-1:0]          w_diff;
    logic [W-1:0]          w_take;
    logic                  w_load_loc;
    logic                  w_load_req;

    assign w_load_loc = (r_state == S_IDLE) && i_in_valid
                        && (i_in_data.func == bfdqc_pkg::FUNC_LOAD_LOC)
                        && (r_lcnt < LC'(MAX_LOCATIONS));
    assign w_load_req = (r_state == S_IDLE) && i_in_valid
                        && (i_in_data.func == bfdqc_pkg::FUNC_LOAD_REQ)
                        && (r_rcnt < RC'(MAX_REQUESTS));

    // The true difference lies in [0, 2^W - 1], so the modulo difference is
    // exact and only its top bit decides whether it saturates.
    assign w_diff = W'(r_best) - W'(r_req);
    assign w_take = w_diff[W-1] ? {1'b0, {(W-1){1'b1}}} : w_diff;

    assign w_loc_we    = w_load_loc || (r_state == S_LFIX);
    assign w_loc_waddr = (r_state == S_LFIX) ? r_bestidx : r_lcnt[LA-1:0];
    assign w_loc_wdata = (r_state == S_LFIX) ? w_take : W'(i_in_data.amount);

    // Removing the chosen request moves the last live entry into its slot.
    assign w_req_we    = w_load_req || (r_state == S_RFIX);
    assign w_req_waddr = (r_state == S_RFIX) ? r_maxidx : r_rcnt[RA-1:0];
    assign w_req_wdata = (r_state == S_RFIX) ? W'(r_last) : W'(i_in_data.amount);

    assign w_loc_rs = w_loc_rdata;
    assign w_req_rs = w_req_rdata;

    bfdqc_ram #(
        .WIDTH (W),
        .DEPTH (MAX_LOCATIONS),
        .AW    (LA)
    ) u_loc_ram (
        .i_clk   (i_clk),
        .i_we    (w_loc_we),
        .i_waddr (w_loc_waddr),
        .i_wdata (w_loc_wdata),
        .i_raddr (r_laddr[LA-1:0]),
        .o_rdata (w_loc_rdata)
    );

    bfdqc_ram #(
        .WIDTH (W),
        .DEPTH (MAX_REQUESTS),
        .AW    (RA)
    ) u_req_ram (
        .i_clk   (i_clk),
        .i_we    (w_req_we),
        .i_waddr (w_req_waddr),
        .i_wdata (w_req_wdata),
        .i_raddr (r_raddr[RA-1:0]),
        .o_rdata (w_req_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lcnt  <= '0;
            r_rcnt  <= '0;
            r_ovf   <= 1'b0;
            r_rd_v  <= 1'b0;
            r_found <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            // In the final state the output register is refilled below instead.
            if (r_out_v && !i_out_stall && (r_state != S_DONE)) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        unique case (i_in_data.func)
                            bfdqc_pkg::FUNC_LOAD_LOC: begin
                                if (w_load_loc) begin
                                    r_lcnt <= r_lcnt + LC'(1);
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            bfdqc_pkg::FUNC_LOAD_REQ: begin
                                if (w_load_req) begin
                                    r_rcnt <= r_rcnt + RC'(1);
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            bfdqc_pkg::FUNC_EVAL: begin
                                r_raddr <= '0;
                                r_rd_v  <= 1'b0;
                                r_state <= S_RSCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RSCAN: begin
                    if (r_raddr < r_rcnt) begin
                        r_raddr   <= r_raddr + RC'(1);
                        r_rd_v    <= 1'b1;
                        r_rd_ridx <= r_raddr[RA-1:0];
                    end else begin
                        r_rd_v <= 1'b0;
                    end
                    if (r_rd_v) begin
                        if (r_rd_ridx == '0 || w_req_rs > r_max) begin
                            r_max    <= w_req_rs;
                            r_maxidx <= r_rd_ridx;
                        end
                        r_last <= w_req_rs;
                    end
                    if (r_rcnt == '0) begin
                        r_ok    <= 1'b1;
                        r_state <= S_DONE;
                    end else if (r_raddr == r_rcnt && !r_rd_v) begin
                        r_state <= S_RFIX;
                    end
                end
                S_RFIX: begin
                    r_rcnt  <= r_rcnt - RC'(1);
                    r_req   <= r_max;
                    r_laddr <= '0;
                    r_rd_v  <= 1'b0;
                    r_found <= 1'b0;
                    r_state <= S_LSCAN;
                end
                S_LSCAN: begin
                    if (r_laddr < r_lcnt) begin
                        r_laddr   <= r_laddr + LC'(1);
                        r_rd_v    <= 1'b1;
                        r_rd_lidx <= r_laddr[LA-1:0];
                    end else begin
                        r_rd_v <= 1'b0;
                    end
                    if (r_rd_v && w_loc_rs >= r_req && (!r_found || w_loc_rs < r_best)) begin
                        r_best    <= w_loc_rs;
                        r_bestidx <= r_rd_lidx;
                        r_found   <= 1'b1;
                    end
                    if (r_laddr == r_lcnt && !r_rd_v) begin
                        if (r_found) begin
                            r_state <= S_LFIX;
                        end else begin
                            r_ok    <= 1'b0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_LFIX: begin
                    r_raddr <= '0;
                    r_rd_v  <= 1'b0;
                    r_state <= S_RSCAN;
                end
                S_DONE: begin
                    if (!r_out_v || !i_out_stall) begin
                        r_out_v             <= 1'b1;
                        r_out.satisfiable   <= r_ok;
                        r_out.overflow      <= r_ovf;
                        r_lcnt              <= '0;
                        r_rcnt              <= '0;
                        r_ovf               <= 1'b0;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    `BFDQC_ASSERT_SAME(a_lcnt_range, 1'b1, r_lcnt <= LC'(MAX_LOCATIONS))
    `BFDQC_ASSERT_SAME(a_rcnt_range, 1'b1, r_rcnt <= RC'(MAX_REQUESTS))
    `BFDQC_ASSERT_SAME(a_fix_has_fit, r_state == S_LFIX, r_found)
    `BFDQC_ASSERT_NEXT(a_done_clears, r_state == S_DONE && (!r_out_v || !i_out_stall), r_out_v && r_lcnt == '0 && r_rcnt == '0 && !r_ovf)

endmodule

FILE: dv/tb_best_fit_decreasing_quota_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_fit_decreasing_quota_check
// Self-checking bench for the quota check. A short directed table covers the
// corner cases. Random load and evaluate sequences follow, idling at random on
// both channels and at the end on neither. Each result beat is compared with the
// table's verdict or else a behavioural best-fit-decreasing placement kept by the bench.
// ----------------------------------------------------------------------------
module tb_best_fit_decreasing_quota_check;

    localparam int AW            = bfdqc_pkg::AMOUNT_WIDTH;
    localparam int LOC_DEPTH     = 16;
    localparam int REQ_DEPTH     = 64;
    localparam int RANDOM_BEATS  = 890;
    localparam int NUM_ROWS      = 24;
    localparam bfdqc_pkg::t_func FUNC_SPARE = 2'd3;

    localparam logic signed [AW-1:0] AMT_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] AMT_MIN = {1'b1, {(AW-1){1'b0}}};

    localparam bfdqc_pkg::t_out_beat FITS         = '{satisfiable: 1'b1, overflow: 1'b0};
    localparam bfdqc_pkg::t_out_beat NO_FIT       = '{satisfiable: 1'b0, overflow: 1'b0};
    localparam bfdqc_pkg::t_out_beat FITS_DROPPED = '{satisfiable: 1'b1, overflow: 1'b1};

    typedef struct packed {
        bfdqc_pkg::t_func     func;
        logic signed [AW-1:0] amount;
        logic [4:0]           reps;
        logic                 typed;
        bfdqc_pkg::t_out_beat verdict;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    bfdqc_pkg::t_in_beat  i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    bfdqc_pkg::t_out_beat o_out_data;

    best_fit_decreasing_quota_check dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the two stores and the dropped-load flag.
    logic signed [AW-1:0] loc_room [LOC_DEPTH];
    logic signed [AW-1:0] req_want [REQ_DEPTH];
    int        loc_fill;
    int        req_fill;
    bit        loads_dropped;

    bfdqc_pkg::t_out_beat verdict_q [$];
    bfdqc_pkg::t_out_beat oldest_verdict;
    t_row                 directed_rows [NUM_ROWS];

    int send_idle_pct;
    int recv_idle_pct;
    int errors;
    int beats_sent;
    int evals_seen;
    int evals_fit;
    int evals_dropped;

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                $error("result beat arrived with no evaluation outstanding");
                errors++;
            end else begin
                oldest_verdict = verdict_q.pop_front();
                if (o_out_data.satisfiable !== oldest_verdict.satisfiable) begin
                    $error("satisfiable: expected %0b, actual %0b",
                           oldest_verdict.satisfiable, o_out_data.satisfiable);
                    errors++;
                end
                if (o_out_data.overflow !== oldest_verdict.overflow) begin
                    $error("overflow: expected %0b, actual %0b",
                           oldest_verdict.overflow, o_out_data.overflow);
                    errors++;
                end
            end
        end
    end

    // Largest request first, each on the tightest location that holds it.
    function automatic bit all_requests_fit();
        longint room [LOC_DEPTH];
        longint want [REQ_DEPTH];
        longint key;
        longint diff;
        int     i;
        int     j;
        int     best;
        for (i = 0; i < loc_fill; i++) room[i] = longint'(loc_room[i]);
        for (i = 0; i < req_fill; i++) want[i] = longint'(req_want[i]);
        for (i = 1; i < req_fill; i++) begin
            key = want[i];
            j = i;
            while (j > 0 && want[j-1] < key) begin
                want[j] = want[j-1];
                j--;
            end
            want[j] = key;
        end
        for (i = 0; i < req_fill; i++) begin
            best = -1;
            for (j = 0; j < loc_fill; j++) begin
                if (room[j] >= want[i] && (best < 0 || room[j] < room[best])) best = j;
            end
            if (best < 0) return 1'b0;
            // A negative request can push the free space past the top of the
            // signed range; it is held at the largest value.
            diff = room[best] - want[i];
            room[best] = (diff > longint'(AMT_MAX)) ? longint'(AMT_MAX) : diff;
        end
        return 1'b1;
    endfunction

    task automatic track_beat(input bfdqc_pkg::t_in_beat beat, input bit typed,
                              input bfdqc_pkg::t_out_beat verdict);
        bfdqc_pkg::t_out_beat predicted;
        bfdqc_pkg::t_out_beat expected;
        case (beat.func)
            bfdqc_pkg::FUNC_LOAD_LOC: begin
                if (loc_fill < LOC_DEPTH) begin
                    loc_room[loc_fill] = beat.amount;
                    loc_fill++;
                end else begin
                    loads_dropped = 1'b1;
                end
            end
            bfdqc_pkg::FUNC_LOAD_REQ: begin
                if (req_fill < REQ_DEPTH) begin
                    req_want[req_fill] = beat.amount;
                    req_fill++;
                end else begin
                    loads_dropped = 1'b1;
                end
            end
            bfdqc_pkg::FUNC_EVAL: begin
                predicted.satisfiable = all_requests_fit();
                predicted.overflow    = loads_dropped;
                expected = typed ? verdict : predicted;
                verdict_q.insert(verdict_q.size(), expected);
                evals_seen++;
                evals_fit     += int'(predicted.satisfiable);
                evals_dropped += int'(predicted.overflow);
                loc_fill      = 0;
                req_fill      = 0;
                loads_dropped = 1'b0;
            end
            default: ;
        endcase
        beats_sent++;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic push_beat(input bfdqc_pkg::t_in_beat beat, input bit typed,
                             input bfdqc_pkg::t_out_beat verdict);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        track_beat(beat, typed, verdict);
        @(negedge i_clk);
    endtask

    function automatic logic signed [AW-1:0] pick_amount(input int shape,
                                                         input bit for_loc);
        logic [63:0] raw;
        int          v;
        raw = {$urandom, $urandom};
        if (shape < 70) v = for_loc ? $urandom_range(999) : $urandom_range(499);
        else if (shape < 82) return raw[AW-1:0];
        else if (shape < 88) begin
            v = $urandom_range(100);
            v = v - 50;
        end else v = for_loc ? $urandom_range(999) : $urandom_range(99);
        return AW'(v);
    endfunction

    // One load sequence closed by an evaluation. Most are well formed with
    // modest amounts; the rest use full-width values, small signed values,
    // or more loads than a store holds.
    task automatic random_sequence();
        int                  shape;
        int                  n_loc;
        int                  n_req;
        bit                  as_loc;
        logic [63:0]         raw;
        bfdqc_pkg::t_in_beat beat;
        shape = $urandom_range(99);
        if (shape < 70) begin
            n_loc = $urandom_range(1, 8);
            n_req = $urandom_range(0, 2 * n_loc);
        end else if (shape < 88) begin
            n_loc = $urandom_range(0, 16);
            n_req = $urandom_range(0, 12);
        end else if (shape < 94) begin
            n_loc = $urandom_range(17, 20);
            n_req = $urandom_range(0, 8);
        end else begin
            n_loc = $urandom_range(0, 16);
            n_req = $urandom_range(60, 68);
        end
        while (n_loc + n_req > 0) begin
            if ($urandom_range(9) == 0) begin
                raw = {$urandom, $urandom};
                beat.func   = FUNC_SPARE;
                beat.amount = raw[AW-1:0];
                push_beat(beat, 1'b0, NO_FIT);
            end
            as_loc = (n_req == 0) || (n_loc > 0 && $urandom_range(n_loc + n_req - 1) < n_loc);
            beat.func   = as_loc ? bfdqc_pkg::FUNC_LOAD_LOC : bfdqc_pkg::FUNC_LOAD_REQ;
            beat.amount = pick_amount(shape, as_loc);
            push_beat(beat, 1'b0, NO_FIT);
            if (as_loc) n_loc--;
            else n_req--;
        end
        raw = {$urandom, $urandom};
        beat.func   = bfdqc_pkg::FUNC_EVAL;
        beat.amount = raw[AW-1:0];
        push_beat(beat, 1'b0, NO_FIT);
    endtask

    initial begin
        bfdqc_pkg::t_in_beat beat;
        int                  random_start;
        int                  phase;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_stall   = 1'b0;
        loc_fill      = 0;
        req_fill      = 0;
        loads_dropped = 1'b0;
        errors        = 0;
        beats_sent    = 0;
        evals_seen    = 0;
        evals_fit     = 0;
        evals_dropped = 0;
        send_idle_pct = 19;
        recv_idle_pct = 62;

        directed_rows = '{
            '{bfdqc_pkg::FUNC_EVAL,     48'sd0,           5'd1,  1'b1, FITS},   // nothing loaded
            '{bfdqc_pkg::FUNC_LOAD_REQ, 48'sd5,           5'd1,  1'b0, '0},
            '{bfdqc_pkg::FUNC_EVAL,     48'sd0,           5'd1,  1'b1, NO_FIT}, // no locations
            '{bfdqc_pkg::FUNC_LOAD_LOC, 48'sd10,          5'd1,  1'b0, '0},
            '{bfdqc_pkg::FUNC_EVAL,     48'sd0,           5'd1,  1'b1, FITS},   // no requests
            '{bfdqc_pkg::FUNC_LOAD_LOC, AMT_MAX,          5'd1,  1'b0, '0},
            '{bfdqc_pkg::FUNC_LOAD_REQ, -48'sd1,          5'd2,  1'b0, '0},
            '{bfdqc_pkg::FUNC_EVAL,     48'sd0,           5'd1,  1'b1, FITS},   // saturation
            '{bfdqc_pkg::FUNC_LOAD_LOC, AMT_MIN,          5'd1,  1'b0, '0},
            '{bfdqc_pkg::FUNC_LOAD_REQ, AMT_MIN,          5'd1,  1'b0, '0},
            '{bfdqc_pkg::FUNC_EVAL,     48'sd0,           5'd1,  1'b1, FITS},
            '{bfdqc_pkg::FUNC_LOAD_LOC, AMT_MIN,          5'd1,  1'b0, '0},
            '{bfdqc_pkg::FUNC_LOAD_REQ, AMT_MIN + 48'sd1, 5'd1,  1'b0, '0},
            '{bfdqc_pkg::FUNC_EVAL,     48'sd0,           5'd1,  1'b1, NO_FIT},
            '{FUNC_SPARE,               -48'sd1,          5'd1,  1'b0, '0},
            '{bfdqc_pkg::FUNC_EVAL,     -48'sd1,          5'd1,  1'b1, FITS},   // spare ignored
            '{bfdqc_pkg::FUNC_LOAD_LOC, 48'sd3,           5'd17, 1'b0, '0},
            '{bfdqc_pkg::FUNC_LOAD_REQ, 48'sd3,           5'd16, 1'b0, '0},
            // The location store is full, so one load is dropped.
            '{bfdqc_pkg::FUNC_EVAL,     48'sd0,           5'd1,  1'b1, FITS_DROPPED},
            '{bfdqc_pkg::FUNC_LOAD_LOC, 48'sd7,           5'd1,  1'b0, '0},
            '{bfdqc_pkg::FUNC_LOAD_LOC, 48'sd5,           5'd1,  1'b0, '0},
            '{bfdqc_pkg::FUNC_LOAD_REQ, 48'sd5,           5'd2,  1'b0, '0},
            '{bfdqc_pkg::FUNC_LOAD_REQ, 48'sd2,           5'd1,  1'b0, '0},
            '{bfdqc_pkg::FUNC_EVAL,     48'sd0,           5'd1,  1'b0, '0}
        };

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            beat.func   = directed_rows[r].func;
            beat.amount = directed_rows[r].amount;
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                push_beat(beat, directed_rows[r].typed, directed_rows[r].verdict);
            end
        end

        // Three idling regimes: sender light, then receiver light, then none.
        random_start = beats_sent;
        while (beats_sent - random_start < RANDOM_BEATS) begin
            phase = (beats_sent - random_start) * 3 / RANDOM_BEATS;
            send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 62 : 0;
            recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 19 : 0;
            random_sequence();
        end
        i_in_valid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("summary: %0d input beats, %0d evaluations checked",
                 beats_sent, evals_seen);
        $display("summary: %0d placements fitted, %0d saw dropped loads",
                 evals_fit, evals_dropped);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
